>>> sv/hnm_pkg.sv
// Shared types, constants and helper functions for the heightmap to normal map block.
// Used by every module of the block but hnm_ram; depends on nothing.
`default_nettype none
package hnm_pkg;

  localparam int SIDE_MAX_DEF = 256;
  localparam int SIDE_W       = 9;
  localparam int SCALE_W      = 16;
  localparam int PADDR_W      = 3;
  localparam logic [SIDE_W-1:0]  SIDE_RESET  = 9'd256;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd256;

  typedef enum logic {
    REG_IMAGE_SIDE   = 1'b0,
    REG_HEIGHT_SCALE = 1'b1
  } reg_idx_e;

  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  // unit step scaled by 256*255
  localparam logic [15:0] UNIT_STEP = 16'd65280;

  localparam int SX_W  = 28;   // scaled cross-product sums, signed
  localparam int SY_W  = 18;   // height-axis sum, unsigned
  localparam int MAG_W = 27;   // magnitude of a component
  localparam int Q_W   = 56;   // squared length
  localparam int L_W   = 28;   // length
  localparam int REM_W = 46;   // divider remainder
  localparam int QT_W  = 17;   // quotient bits
  localparam int FRAC  = 14;   // Q2.14
  localparam logic [QT_W-1:0] N_ONE = 17'd16384;
  localparam logic [7:0] NORM_ZERO  = 8'd127;

  typedef struct packed {
    logic [7:0] h0;
    logic [7:0] nb_right;
    logic [7:0] nb_below;
    logic [7:0] nb_left;
    logic [7:0] nb_above;
    logic [3:0] ok;        // right, below, left, above inside image
    logic       last;
  } rec_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_RD0,
    F_RD1,
    F_PUSH
  } front_state_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SCALE,
    B_SQUARE,
    B_SQRT,
    B_DINIT,
    B_DIV,
    B_OUT
  } back_state_e;

  // height difference times pair count (0, 1 or 2)
  function automatic logic signed [11:0] weight(input logic signed [11:0] d,
                                                input logic [1:0] cnt);
    logic signed [11:0] r;
    case (cnt)
      2'd1:    r = d;
      2'd2:    r = d <<< 1;
      default: r = '0;
    endcase
    return r;
  endfunction

  // clamp quotient, apply sign, map (n+1)*127.5 truncated
  function automatic logic [7:0] map_out(input logic neg, input logic [QT_W-1:0] q);
    logic [QT_W-1:0] m;
    logic [15:0]     u;
    logic [23:0]     p;
    m = (q > N_ONE) ? N_ONE : q;
    u = neg ? 16'(N_ONE - m) : 16'(N_ONE + m);
    p = 24'(u) * 24'd255;
    return p[22:15];
  endfunction

endpackage
`default_nettype wire

>>> sv/heightmap_to_normal_map.sv
// Heightmap to normal map, 4-neighbour cross scheme. Pixels go in raster order;
// results lag one row, and one flush request per pixel after the last row pushes
// the final row out (tlast on the image's last pixel). Registers: image_side at
// 0x0 (clamped to 2..SIDE_MAX, a write restarts the image), height_scale at 0x4
// (Q8.8). The front end takes each request through F_IDLE, F_RD0, F_RD1, F_PUSH;
// a pixel that yields a result then passes the back end, which is paced by the
// 28-step square root and the 17-step divider lanes and takes a new record only
// once the last is out. Row 0 pushes nothing. Line buffers need no clearing.
// Depends on hnm_pkg, hnm_front, hnm_fifo, hnm_back.
`default_nettype none
module heightmap_to_normal_map #(
  parameter int SIDE_MAX = hnm_pkg::SIDE_MAX_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        s_axis_tvalid,
  output      logic                        s_axis_tready,
  input  wire logic [7:0]                  s_axis_tdata,   // [7:0] height
  input  wire logic [0:0]                  s_axis_tuser,   // [0] action
  output      logic                        m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  // [7:0] normal_x, [15:8] normal_y, [23:16] normal_z, [31:24] height_out
  output      logic [31:0]                 m_axis_tdata,
  output      logic                        m_axis_tlast,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [hnm_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output      logic [31:0]                 prdata,
  output      logic                        pready
);

  localparam int SW = $clog2(SIDE_MAX+1);

  logic [hnm_pkg::SIDE_W-1:0]  side_q;
  logic [hnm_pkg::SCALE_W-1:0] scale_q;
  logic [SW-1:0]               side_used;
  logic                        wr, clr;
  hnm_pkg::reg_idx_e           idx;

  logic          push, push_ready, q_valid, pop;
  hnm_pkg::rec_t rec_in, rec_out;

  assign pready = 1'b1;
  assign idx    = hnm_pkg::reg_idx_e'(paddr[2]);
  assign wr     = psel && penable && pwrite && pready;
  assign clr    = wr && (idx == hnm_pkg::REG_IMAGE_SIDE);

  always_comb begin
    case (idx)
      hnm_pkg::REG_IMAGE_SIDE:   prdata = 32'(side_q);
      hnm_pkg::REG_HEIGHT_SCALE: prdata = 32'(scale_q);
      default:                   prdata = '0;
    endcase
  end

  always_comb begin
    if (side_q < 9'd2) begin
      side_used = SW'(2);
    end else if (32'(side_q) > 32'(SIDE_MAX)) begin
      side_used = SW'(SIDE_MAX);
    end else begin
      side_used = SW'(side_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q  <= hnm_pkg::SIDE_RESET;
      scale_q <= hnm_pkg::SCALE_RESET;
    end else if (wr) begin
      case (idx)
        hnm_pkg::REG_IMAGE_SIDE:   side_q  <= pwdata[hnm_pkg::SIDE_W-1:0];
        hnm_pkg::REG_HEIGHT_SCALE: scale_q <= pwdata[hnm_pkg::SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  hnm_front #(.SIDE_MAX(SIDE_MAX)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .clr_i        (clr),
    .side_i       (side_used),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .action_i     (s_axis_tuser[0]),
    .height_i     (s_axis_tdata),
    .push_o       (push),
    .rec_o        (rec_in),
    .push_ready_i (push_ready)
  );

  hnm_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .rec_i   (rec_in),
    .ready_o (push_ready),
    .valid_o (q_valid),
    .rec_o   (rec_out),
    .pop_i   (pop)
  );

  hnm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .scale_i     (scale_q),
    .q_valid_i   (q_valid),
    .rec_i       (rec_out),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule
`default_nettype wire

>>> sv/hnm_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`default_nettype none
module hnm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

>>> sv/hnm_front.sv
// Front end: accepts pixels and flush requests, tracks position, reads the line
// buffers and builds a neighbour record. Depends on hnm_pkg and hnm_ram.
`default_nettype none
module hnm_front #(
  parameter int SIDE_MAX = hnm_pkg::SIDE_MAX_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          clr_i,
  input  wire logic [$clog2(SIDE_MAX+1)-1:0] side_i,
  input  wire logic                          in_valid_i,
  output      logic                          in_ready_o,
  input  wire logic                          action_i,
  input  wire logic [7:0]                    height_i,
  output      logic                          push_o,
  output      hnm_pkg::rec_t                 rec_o,
  input  wire logic                          push_ready_i
);

  localparam int CW = $clog2(SIDE_MAX);
  localparam int SW = $clog2(SIDE_MAX+1);

  hnm_pkg::front_state_e state_q, state_d;

  logic [CW-1:0] col_q;
  logic [SW-1:0] row_q;
  logic [7:0]    hin_q, h0_q, above_q, right_q, left_q;
  logic          flush_q;

  logic [SW:0]   col_nx;
  logic          not_end, flushing, take, advance, row0;
  logic [CW-1:0] cur_raddr;
  logic          cur_we;
  logic [7:0]    cur_rdata, above_rdata;

  assign col_nx   = (SW+1)'(col_q) + 1'b1;
  assign not_end  = col_nx < {1'b0, side_i};
  assign flushing = row_q >= side_i;
  assign row0     = row_q == '0;
  assign take     = in_valid_i && in_ready_o &&
                    ((action_i == hnm_pkg::ACT_FLUSH) == flushing);
  assign advance  = (state_q == hnm_pkg::F_PUSH) && (row0 || push_ready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      hnm_pkg::F_IDLE: if (take) state_d = hnm_pkg::F_RD0;
      hnm_pkg::F_RD0:  state_d = hnm_pkg::F_RD1;
      hnm_pkg::F_RD1:  state_d = hnm_pkg::F_PUSH;
      hnm_pkg::F_PUSH: if (advance) state_d = hnm_pkg::F_IDLE;
      default:         state_d = hnm_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = state_q == hnm_pkg::F_IDLE;
    cur_raddr  = (state_q == hnm_pkg::F_RD0) ? CW'(col_nx) : col_q;
    push_o     = advance && !row0;
    cur_we     = advance && !flush_q;
  end

  always_comb begin
    rec_o.h0       = h0_q;
    rec_o.nb_right = right_q;
    rec_o.nb_below = hin_q;
    rec_o.nb_left  = left_q;
    rec_o.nb_above = above_q;
    rec_o.ok       = {row_q > SW'(1), col_q != '0, !flush_q, not_end};
    rec_o.last     = flush_q && !not_end;
  end

  hnm_ram #(.WIDTH(8), .DEPTH(SIDE_MAX)) u_cur_ram (
    .clk_i   (clk_i),
    .we_i    (cur_we),
    .waddr_i (col_q),
    .wdata_i (hin_q),
    .raddr_i (cur_raddr),
    .rdata_o (cur_rdata)
  );

  hnm_ram #(.WIDTH(8), .DEPTH(SIDE_MAX)) u_above_ram (
    .clk_i   (clk_i),
    .we_i    (push_o),
    .waddr_i (col_q),
    .wdata_i (h0_q),
    .raddr_i (col_q),
    .rdata_o (above_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hnm_pkg::F_IDLE;
      col_q   <= '0;
      row_q   <= '0;
    end else begin
      state_q <= state_d;
      if (clr_i) begin
        col_q <= '0;
        row_q <= '0;
      end else if (advance) begin
        if (not_end) begin
          col_q <= CW'(col_nx);
        end else begin
          col_q <= '0;
          row_q <= flush_q ? '0 : row_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      hin_q   <= height_i;
      flush_q <= flushing;
    end
    if (state_q == hnm_pkg::F_RD0) begin
      h0_q    <= cur_rdata;
      above_q <= above_rdata;
    end
    if (state_q == hnm_pkg::F_RD1) begin
      right_q <= cur_rdata;
    end
    // left neighbour in the row above is the previous pixel's center
    if (push_o) begin
      left_q <= h0_q;
    end
  end

endmodule
`default_nettype wire

>>> sv/hnm_fifo.sv
// Two-entry queue of neighbour records between front and back end.
// Depends on hnm_pkg.
`default_nettype none
module hnm_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire hnm_pkg::rec_t rec_i,
  output      logic          ready_o,
  output      logic          valid_o,
  output      hnm_pkg::rec_t rec_o,
  input  wire logic          pop_i
);

  hnm_pkg::rec_t mem_q [2];
  logic          wptr_q, rptr_q;
  logic [1:0]    cnt_q;

  assign ready_o = cnt_q != 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign rec_o   = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) wptr_q <= !wptr_q;
      if (pop_i)  rptr_q <= !rptr_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= rec_i;
    end
  end

endmodule
`default_nettype wire

>>> sv/hnm_back.sv
// Back end: cross-product sums, squared length, bit-pair square root, three
// restoring divider lanes and output register. Depends on hnm_pkg.
`default_nettype none
module hnm_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [hnm_pkg::SCALE_W-1:0]   scale_i,
  input  wire logic                          q_valid_i,
  input  wire hnm_pkg::rec_t                 rec_i,
  output      logic                          pop_o,
  output      logic                          out_valid_o,
  input  wire logic                          out_ready_i,
  output      logic [31:0]                   out_data_o,
  output      logic                          out_last_o
);

  localparam int SX_W  = hnm_pkg::SX_W;
  localparam int SY_W  = hnm_pkg::SY_W;
  localparam int MAG_W = hnm_pkg::MAG_W;
  localparam int Q_W   = hnm_pkg::Q_W;
  localparam int L_W   = hnm_pkg::L_W;
  localparam int REM_W = hnm_pkg::REM_W;
  localparam int QT_W  = hnm_pkg::QT_W;

  hnm_pkg::back_state_e state_q, state_d;

  logic signed [11:0] d0, d1, d2, d3, dx_d, dz_d;
  logic               p0, p1, p2, p3;
  logic [2:0]         np_d;

  logic signed [11:0]   dx_q, dz_q;
  logic [2:0]           np_q;
  logic [7:0]           h0_q;
  logic                 last_q;
  logic signed [SX_W-1:0] sx_q, sz_q;
  logic [SY_W-1:0]      sy_q;
  logic [4:0]           cnt_q;
  logic [Q_W-1:0]       prod_q, acc_q, v_q, res_q, bit_q, trial;
  logic [L_W-1:0]       len_q;
  logic [REM_W-1:0]     dv_q;
  logic [REM_W-1:0]     rem_q [3];
  logic [QT_W-1:0]      quo_q [3];
  logic [MAG_W-1:0]     mag [3];
  logic [MAG_W-1:0]     op;
  logic                 load;

  logic        out_valid_q;
  logic [31:0] out_data_q;
  logic        out_last_q;

  // pair terms: sx = -y0*(p0+p3) + y2*(p1+p2), sz = -y1*(p0+p1) + y3*(p2+p3)
  always_comb begin
    d0 = $signed({4'b0, rec_i.nb_right}) - $signed({4'b0, rec_i.h0});
    d1 = $signed({4'b0, rec_i.nb_below}) - $signed({4'b0, rec_i.h0});
    d2 = $signed({4'b0, rec_i.nb_left})  - $signed({4'b0, rec_i.h0});
    d3 = $signed({4'b0, rec_i.nb_above}) - $signed({4'b0, rec_i.h0});
    p0 = rec_i.ok[0] && rec_i.ok[1];
    p1 = rec_i.ok[1] && rec_i.ok[2];
    p2 = rec_i.ok[2] && rec_i.ok[3];
    p3 = rec_i.ok[3] && rec_i.ok[0];
    dx_d = hnm_pkg::weight(d2, 2'(p1) + 2'(p2)) - hnm_pkg::weight(d0, 2'(p0) + 2'(p3));
    dz_d = hnm_pkg::weight(d3, 2'(p2) + 2'(p3)) - hnm_pkg::weight(d1, 2'(p0) + 2'(p1));
    np_d = 3'(p0) + 3'(p1) + 3'(p2) + 3'(p3);
  end

  always_comb begin
    mag[0] = sx_q[SX_W-1] ? MAG_W'(-sx_q) : MAG_W'(sx_q);
    mag[1] = MAG_W'(sy_q);
    mag[2] = sz_q[SX_W-1] ? MAG_W'(-sz_q) : MAG_W'(sz_q);
    case (cnt_q)
      5'd0:    op = mag[0];
      5'd1:    op = mag[2];
      default: op = mag[1];
    endcase
    trial = res_q + bit_q;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      hnm_pkg::B_IDLE:   if (q_valid_i) state_d = hnm_pkg::B_SCALE;
      hnm_pkg::B_SCALE:  state_d = hnm_pkg::B_SQUARE;
      hnm_pkg::B_SQUARE: if (cnt_q == 5'd3) state_d = hnm_pkg::B_SQRT;
      hnm_pkg::B_SQRT:   if (bit_q[0]) state_d = hnm_pkg::B_DINIT;
      hnm_pkg::B_DINIT:  state_d = hnm_pkg::B_DIV;
      hnm_pkg::B_DIV:    if (cnt_q == 5'(QT_W-1)) state_d = hnm_pkg::B_OUT;
      hnm_pkg::B_OUT:    if (load) state_d = hnm_pkg::B_IDLE;
      default:           state_d = hnm_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    pop_o = (state_q == hnm_pkg::B_IDLE) && q_valid_i;
    load  = (state_q == hnm_pkg::B_OUT) && (!out_valid_q || out_ready_i);
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_last_o  = out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hnm_pkg::B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      hnm_pkg::B_IDLE: begin
        dx_q   <= dx_d;
        dz_q   <= dz_d;
        np_q   <= np_d;
        h0_q   <= rec_i.h0;
        last_q <= rec_i.last;
      end
      hnm_pkg::B_SCALE: begin
        sx_q  <= SX_W'(dx_q) * SX_W'($signed({1'b0, scale_i}));
        sz_q  <= SX_W'(dz_q) * SX_W'($signed({1'b0, scale_i}));
        sy_q  <= SY_W'(np_q) * SY_W'(hnm_pkg::UNIT_STEP);
        cnt_q <= '0;
      end
      hnm_pkg::B_SQUARE: begin
        prod_q <= Q_W'(op) * Q_W'(op);
        acc_q  <= (cnt_q == 5'd0) ? '0 : acc_q + prod_q;
        cnt_q  <= cnt_q + 1'b1;
        if (cnt_q == 5'd3) begin
          v_q   <= acc_q + prod_q;
          res_q <= '0;
          bit_q <= Q_W'(1) << (Q_W - 2);
        end
      end
      hnm_pkg::B_SQRT: begin
        if (v_q >= trial) begin
          v_q   <= v_q - trial;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      hnm_pkg::B_DINIT: begin
        len_q <= L_W'(res_q);
        dv_q  <= REM_W'(res_q) << (QT_W - 1);
        cnt_q <= '0;
        for (int i = 0; i < 3; i++) begin
          rem_q[i] <= REM_W'(mag[i]) << hnm_pkg::FRAC;
          quo_q[i] <= '0;
        end
      end
      hnm_pkg::B_DIV: begin
        for (int i = 0; i < 3; i++) begin
          if (rem_q[i] >= dv_q) begin
            rem_q[i] <= rem_q[i] - dv_q;
            quo_q[i] <= {quo_q[i][QT_W-2:0], 1'b1};
          end else begin
            quo_q[i] <= {quo_q[i][QT_W-2:0], 1'b0};
          end
        end
        dv_q  <= dv_q >> 1;
        cnt_q <= cnt_q + 1'b1;
      end
      hnm_pkg::B_OUT: begin
        if (load) begin
          if (len_q == '0) begin
            out_data_q <= {h0_q, hnm_pkg::NORM_ZERO, hnm_pkg::NORM_ZERO, hnm_pkg::NORM_ZERO};
          end else begin
            out_data_q <= {h0_q,
                           hnm_pkg::map_out(sz_q[SX_W-1], quo_q[2]),
                           hnm_pkg::map_out(1'b0, quo_q[1]),
                           hnm_pkg::map_out(sx_q[SX_W-1], quo_q[0])};
          end
          out_last_q <= last_q;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire
